// ----- sv/three_stacks_shared_memory_top_assert.svh -----
// Assertion macros shared by the checker of the three-stack block.
`ifndef THREE_STACKS_SHARED_MEMORY_TOP_ASSERT_SVH
`define THREE_STACKS_SHARED_MEMORY_TOP_ASSERT_SVH

// Clocked assertion that is off while reset is held.
`define TSSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TSSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/tssm_pkg.sv -----
// Types and constants of the three-stack shared memory block.
package tssm_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int NUM_STACKS  = 3;
  localparam int MEM_DEPTH   = NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int LIMIT_W     = 9;
  localparam int CMP_W       = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
  localparam int OP_W        = 2;
  localparam int SEL_W       = 2;
  localparam int DATA_W      = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [SEL_W-1:0]         stack_select;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic                     ok;
    logic                     top_valid;
    logic signed [DATA_W-1:0] top_value;
  } out_item_t;

endpackage

// ----- sv/three_stacks_shared_memory_top.sv -----
// Top level of the three-stack shared memory block.
// Three stacks live in one synchronous memory of 3 x STACK_DEPTH words, each stack in a fixed
// region, with fill counts held in flip-flops and a write-only limit register (cfg_stack_limit,
// capped at STACK_DEPTH, reset 256). Every input transfer gives exactly one result transfer.
// The fill count is updated and the new top is read from the memory in the cycle the item is
// taken (ST_IDLE), and the read data comes back in the next cycle (ST_READ), so no new item is
// taken while in ST_READ. A pushed value is reported straight from the input
// rather than read back. Results pass through an output register and one skid register, so
// the next item is taken while a result waits. No clearing pass is needed after reset.
module three_stacks_shared_memory_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tssm_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tssm_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tssm_pkg::LIMIT_W-1:0]  cfg_stack_limit
);
  import tssm_pkg::*;

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  logic [DATA_W-1:0] mem_r [MEM_DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  logic [FILL_W-1:0]  fill_r [NUM_STACKS];
  logic [LIMIT_W-1:0] limit_r;
  state_t             state_r;
  state_t             state_nxt;

  logic                     ok_r;
  logic                     top_valid_r;
  logic                     fwd_r;
  logic signed [DATA_W-1:0] push_value_r;
  out_item_t                out_r;
  logic                     out_valid_r;
  out_item_t                skid_r;
  logic                     skid_valid_r;

  logic              accept;
  logic              sel_ok;
  logic [SEL_W-1:0]  sel_idx;
  logic [FILL_W-1:0] cur_fill;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W-1:0] top_fill;
  logic [CMP_W-1:0]  lim_eff;
  logic              op_ok;
  logic              wr_en;
  logic              rd_en;
  logic              new_top_valid;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  out_item_t         result;
  logic              out_free;

  assign in_stall  = (state_r != ST_IDLE) || skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign sel_ok   = in_data.stack_select < SEL_W'(NUM_STACKS);
  assign sel_idx  = sel_ok ? in_data.stack_select : '0;
  assign cur_fill = fill_r[sel_idx];
  assign lim_eff  = (CMP_W'(limit_r) > CMP_W'(STACK_DEPTH)) ? CMP_W'(STACK_DEPTH)
                                                             : CMP_W'(limit_r);

  always_comb begin
    fill_nxt = cur_fill;
    op_ok    = 1'b0;
    wr_en    = 1'b0;
    case (in_data.op)
      OP_PUSH: begin
        if (CMP_W'(cur_fill) < lim_eff) begin
          fill_nxt = cur_fill + FILL_W'(1);
          op_ok    = 1'b1;
          wr_en    = 1'b1;
        end
      end
      OP_POP: begin
        if (cur_fill != '0) begin
          fill_nxt = cur_fill - FILL_W'(1);
          op_ok    = 1'b1;
        end
      end
      OP_PEEK: op_ok = 1'b1;
      default: op_ok = 1'b0;
    endcase
    if (!sel_ok) begin
      fill_nxt = cur_fill;
      op_ok    = 1'b0;
      wr_en    = 1'b0;
    end
  end

  assign new_top_valid = sel_ok && (fill_nxt != '0);
  assign top_fill      = fill_nxt - FILL_W'(1);
  assign base_addr     = ADDR_W'(STACK_DEPTH) * ADDR_W'(sel_idx);
  assign wr_addr       = base_addr + ADDR_W'(cur_fill[IDX_W-1:0]);
  assign rd_addr       = base_addr + ADDR_W'(top_fill[IDX_W-1:0]);
  assign rd_en         = accept && new_top_valid && !wr_en;

  // The pushed word is the new top, so it is forwarded instead of read back.
  always_comb begin
    result.ok        = ok_r;
    result.top_valid = top_valid_r;
    if (!top_valid_r) begin
      result.top_value = '0;
    end else if (fwd_r) begin
      result.top_value = push_value_r;
    end else begin
      result.top_value = rd_data_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en && sel_ok) begin
      mem_r[wr_addr] <= in_data.push_value;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      limit_r      <= LIMIT_RESET;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_stack_limit;
      end
      if (accept) begin
        if (sel_ok) begin
          fill_r[sel_idx] <= fill_nxt;
        end
        ok_r         <= op_ok;
        top_valid_r  <= new_top_valid;
        fwd_r        <= wr_en;
        push_value_r <= in_data.push_value;
      end
      // A new result goes to the output register when it is free, else into the skid.
      if (skid_valid_r && out_free) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else if (state_r == ST_READ) begin
        if (out_free) begin
          out_r       <= result;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= result;
          skid_valid_r <= 1'b1;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/tssm_checker.sv -----
// Port-level checker for the three-stack shared memory block, bound to its top level.
`include "three_stacks_shared_memory_top_assert.svh"

module tssm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tssm_pkg::out_item_t out_data
);
  import tssm_pkg::*;

  `TSSM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed or vanished")
  `TSSM_ASSERT(a_one_per_two, in_valid && !in_stall |=> in_stall, "input taken in two cycles running")
  `TSSM_ASSERT(a_empty_zero, out_valid && !out_data.top_valid |-> out_data.top_value == '0, "empty stack reported a nonzero top")
  `TSSM_ASSERT(a_latency, in_valid && !in_stall && !out_valid |=> ##1 out_valid, "result late with output free")
  `TSSM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "block not idle after reset")

endmodule

bind three_stacks_shared_memory_top tssm_checker u_tssm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/three_stacks_shared_memory_top_tb.sv -----
// Self-checking testbench for the three-stack shared memory block.
module three_stacks_shared_memory_top_tb;
  import tssm_pkg::*;

  localparam logic [OP_W-1:0]  OP_RESERVED = 2'd3;
  localparam logic [SEL_W-1:0] SEL_NONE    = 2'd3;

  // Tracks the fill counts and contents of the three stacks and holds the
  // results the block still owes.
  class stack_scoreboard;
    logic [DATA_W-1:0] store [NUM_STACKS][STACK_DEPTH];
    int unsigned fill [NUM_STACKS];
    int unsigned limit;
    out_item_t owed_q [$];
    int errors;

    function new();
      foreach (fill[s]) fill[s] = 0;
      limit = LIMIT_RESET;
      errors = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit = v;
    endfunction

    function int unsigned fill_of(int s);
      return fill[s];
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      int unsigned cap;
      int unsigned f;
      int s;
      r = '0;
      cap = (limit > STACK_DEPTH) ? STACK_DEPTH : limit;
      if (it.stack_select != SEL_NONE) begin
        s = int'(it.stack_select);
        f = fill[s];
        case (it.op)
          OP_PUSH: begin
            if (f < cap) begin
              store[s][f] = it.push_value;
              f++;
              r.ok = 1'b1;
            end
          end
          OP_POP: begin
            if (f > 0) begin
              f--;
              r.ok = 1'b1;
            end
          end
          OP_PEEK: r.ok = 1'b1;
          default: ;
        endcase
        fill[s] = f;
        if (f > 0) begin
          r.top_valid = 1'b1;
          r.top_value = store[s][f-1];
        end
      end
      owed_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        $error("result transfer with nothing owed: ok=%0b top_valid=%0b top_value=%0d",
               got.ok, got.top_valid, got.top_value);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0b, got %0b", want.ok, got.ok);
        errors++;
      end
      if (got.top_valid !== want.top_valid) begin
        $error("top_valid: expected %0b, got %0b", want.top_valid, got.top_valid);
        errors++;
      end
      if (got.top_value !== want.top_value) begin
        $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_stack_limit = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  stack_scoreboard sb;

  three_stacks_shared_memory_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_stack_limit (cfg_stack_limit)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic in_item_t make_item(logic [OP_W-1:0] op, logic [SEL_W-1:0] sel,
                                         logic [DATA_W-1:0] value);
    in_item_t it;
    it.op = op;
    it.stack_select = sel;
    it.push_value = value;
    return it;
  endfunction

  function automatic in_item_t random_item(int push_pct);
    in_item_t it;
    int r;
    r = $urandom_range(99);
    if (r < push_pct) it.op = OP_PUSH;
    else if (r < 95) it.op = ($urandom_range(99) < 70) ? OP_POP : OP_PEEK;
    else it.op = OP_RESERVED;
    it.stack_select = ($urandom_range(99) < 4) ? SEL_NONE : SEL_W'($urandom_range(2));
    case ($urandom_range(11))
      0: it.push_value = 32'h8000_0000;
      1: it.push_value = 32'h7FFF_FFFF;
      2: it.push_value = 32'h0000_0000;
      3: it.push_value = 32'hFFFF_FFFF;
      default: it.push_value = $urandom;
    endcase
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // The limit only changes once the block has gone quiet.
  task automatic write_limit(logic [LIMIT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_stack_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_limit(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int count, int push_pct);
    repeat (count) send_item(random_item(push_pct));
  endtask

  initial begin
    sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 22;
    recv_idle_pct = 45;
    write_limit(9'd2);
    send_item(make_item(OP_POP, 2'd0, 32'h0));
    send_item(make_item(OP_PEEK, 2'd0, 32'h0));
    send_item(make_item(OP_RESERVED, 2'd0, 32'h0));
    send_item(make_item(OP_PUSH, SEL_NONE, 32'h7FFF_FFFF));
    send_item(make_item(OP_PEEK, SEL_NONE, 32'h0));
    send_item(make_item(OP_PUSH, 2'd0, 32'h8000_0000));
    send_item(make_item(OP_PUSH, 2'd0, 32'h7FFF_FFFF));
    send_item(make_item(OP_PUSH, 2'd0, 32'h1234_5678));
    send_item(make_item(OP_PEEK, 2'd0, 32'h0));
    send_item(make_item(OP_RESERVED, 2'd0, 32'hFFFF_FFFF));
    send_item(make_item(OP_POP, 2'd0, 32'h0));
    send_item(make_item(OP_POP, 2'd0, 32'h0));
    send_item(make_item(OP_POP, 2'd0, 32'h0));
    send_item(make_item(OP_PUSH, 2'd1, 32'hFFFF_FFFF));
    send_item(make_item(OP_PUSH, 2'd2, 32'h0000_0000));
    send_item(make_item(OP_PUSH, 2'd2, 32'hAAAA_AAAA));
    send_item(make_item(OP_PUSH, 2'd2, 32'h5555_5555));
    send_item(make_item(OP_PEEK, 2'd1, 32'h0));
    send_item(make_item(OP_POP, 2'd2, 32'h0));
    send_item(make_item(OP_POP, 2'd1, 32'h0));
    send_item(make_item(OP_POP, SEL_NONE, 32'h0));
    send_item(make_item(OP_PEEK, 2'd2, 32'h0));

    write_limit(9'd1);
    run_random(40, 50);
    write_limit(9'd20);
    run_random(80, 65);

    send_idle_pct = 45;
    recv_idle_pct = 22;
    // Lowering the limit under the fills reached above blocks pushes until pops catch up.
    write_limit(9'd3);
    run_random(40, 35);
    write_limit(9'd0);
    run_random(30, 60);
    write_limit(9'd256);
    while (sb.fill_of(0) < STACK_DEPTH) send_item(make_item(OP_PUSH, 2'd0, $urandom));
    send_item(make_item(OP_PUSH, 2'd0, $urandom));
    send_item(make_item(OP_PEEK, 2'd0, 32'h0));
    send_item(make_item(OP_POP, 2'd0, 32'h0));
    send_item(make_item(OP_PUSH, 2'd0, $urandom));
    send_item(make_item(OP_PUSH, 2'd0, $urandom));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(9'd511);
    run_random(90, 55);

    drain();
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #100000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
